FILE: rtl/core/tofm_pkg.sv
// shared widths, constants, codes and types of the time-of-flight mass calculator
`default_nettype none

package tofm_pkg;

	// field and register widths
	localparam int TOF_W      = 20;
	localparam int MOM_W      = 24;
	localparam int PATH_W     = 16;
	localparam int LIGHT_W    = 20;
	localparam int CFG_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int MASS_W     = 32;

	// stream widths
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 1;

	// times carry eight fraction bits (units of 1/256 ps)
	localparam int Q_FRAC     = 8;
	localparam int TC_W       = LIGHT_W + Q_FRAC;
	localparam int TOFSQ_W    = 2 * TOF_W;
	localparam int SQ_W       = 2 * TC_W;
	localparam int ROOT_W     = TC_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int PROD_W     = MOM_W + ROOT_W;
	localparam int QUO_W      = MASS_W - 1;
	localparam int HI_W       = PROD_W - QUO_W;

	// reference time from path length: floor(path * 128e9 / 149896229)
	// estimate with a reciprocal scaled by 2^20 (never above the exact ratio,
	// short of it by less than 2^-20), so the estimate is low by at most one;
	// the residue, below 2 * 149896229, is worked in its low 29 bits only
	// with 128e9 = 1953125 * 2^16
	localparam int TC_K_W      = 21;
	localparam logic [TC_K_W-1:0] TC_K = 21'd1953125;
	localparam int TC_K_SHIFT  = 16;
	localparam int RECIP_W     = 30;
	localparam logic [RECIP_W-1:0] TC_RECIP = 30'd895404299;
	localparam int RECIP_SHIFT = 20;
	localparam int EST_W       = PATH_W + RECIP_W;
	localparam int RES_W       = TC_W + 1;
	localparam int NLO_W       = RES_W - TC_K_SHIFT;
	localparam logic [TC_W-1:0] TC_DEN = 28'd149896229;

	localparam logic [PATH_W-1:0] PATH_RESET = 16'd6685;
	localparam logic [MASS_W-1:0] MASS_MAX   = 32'h7FFF_FFFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT = 2'd1;

	// reference time sequencer
	typedef enum logic [3:0] {
		TC_MUL  = 4'b0001,
		TC_QD   = 4'b0010,
		TC_FIX  = 4'b0100,
		TC_DONE = 4'b1000
	} tc_state_t;

	// request entering the arithmetic pipeline
	typedef struct packed {
		logic [TOF_W-1:0] tof;
		logic [MOM_W-1:0] mom;
		logic [TC_W-1:0]  tc;
	} req_t;

	// per-item sideband carried down the pipeline
	typedef struct packed {
		logic [MOM_W-1:0] mom;
		logic [TC_W-1:0]  tc;
		logic             neg;
		logic             zero;
	} side_t;

	// finished result
	typedef struct packed {
		logic [MASS_W-1:0] mass;
		logic              sat;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/tof_mass_calculator.sv
// top level: configuration registers, reference time unit, arithmetic pipeline, output skid
`default_nettype none

// Time-of-flight mass calculator. Each request on the s_ side carries a time of
// flight and a momentum; one result per request leaves on the m_ side with the
// signed mass m = p * sqrt((tof/tc)^2 - 1) (negated p * sqrt(1 - (tof/tc)^2) when
// faster than light) and a saturation flag. A request is taken every clock while the
// skid is free and the reference time is ready; it passes the 28 one-bit square
// root stages and 31 one-bit divide stages of the arithmetic pipeline. An output
// register plus a skid register keep requests flowing while a result waits.
// When light_time_ps is zero the reference time comes from path_length_mm through
// a reciprocal multiply, a back multiply and one correction step: after reset and
// after every write of path_length_mm, s_tready stays low while it runs.

module tof_mass_calculator (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tofm_pkg::S_TDATA_W-1:0]  s_tdata,   // tof_ps[19:0], momentum_kev[43:20], zero pad
	// master result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tofm_pkg::M_TDATA_W-1:0]  m_tdata,   // mass_kev[31:0]
	output logic [tofm_pkg::M_TUSER_W-1:0]  m_tuser,   // saturated[0]
	// configuration write port
	input  logic                            cfg_we,
	input  logic [tofm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tofm_pkg::CFG_W-1:0]      cfg_data
);

	logic [tofm_pkg::PATH_W-1:0]   path_q;
	logic [tofm_pkg::LIGHT_W-1:0]  light_q;

	tofm_pkg::tc_state_t           tc_st_q;
	logic [tofm_pkg::EST_W-1:0]    tc_est_q;
	logic [tofm_pkg::RES_W-1:0]    tc_nlo_q;
	logic [tofm_pkg::RES_W-1:0]    tc_qd_q;
	logic [tofm_pkg::TC_W-1:0]     tc_q;
	logic [tofm_pkg::TC_W-1:0]     tc_est;
	logic [tofm_pkg::RES_W-1:0]    tc_res;
	logic [tofm_pkg::TC_W-1:0]     tc_sel;

	logic                          adv;
	logic                          in_vld;
	tofm_pkg::req_t                in_req;
	logic                          p_vld;
	tofm_pkg::res_t                p_res;

	logic                          out_vld_q;
	tofm_pkg::res_t                out_res_q;
	logic                          skid_vld_q;
	tofm_pkg::res_t                skid_res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_q  <= tofm_pkg::PATH_RESET;
			light_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tofm_pkg::CFG_PATH:  path_q  <= cfg_data[tofm_pkg::PATH_W-1:0];
				tofm_pkg::CFG_LIGHT: light_q <= cfg_data[tofm_pkg::LIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// reference time sequencer, restarted by a path length write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_st_q <= tofm_pkg::TC_MUL;
		end else if (cfg_we && cfg_idx == tofm_pkg::CFG_PATH) begin
			tc_st_q <= tofm_pkg::TC_MUL;
		end else begin
			unique case (tc_st_q)
				tofm_pkg::TC_MUL:  tc_st_q <= tofm_pkg::TC_QD;
				tofm_pkg::TC_QD:   tc_st_q <= tofm_pkg::TC_FIX;
				tofm_pkg::TC_FIX:  tc_st_q <= tofm_pkg::TC_DONE;
				tofm_pkg::TC_DONE: ;
				default: tc_st_q <= tofm_pkg::TC_MUL;
			endcase
		end
	end

	// estimate is the exact quotient or one short; the residue decides
	assign tc_est = tofm_pkg::TC_W'(tc_est_q[tofm_pkg::EST_W-1:tofm_pkg::RECIP_SHIFT]);
	assign tc_res = tc_nlo_q - tc_qd_q;

	// path * 128e9 / 149896229 by reciprocal, back multiply and correction
	always_ff @(posedge clk) begin
		case (tc_st_q)
			tofm_pkg::TC_MUL: begin
				tc_est_q <= tofm_pkg::EST_W'(path_q) * tofm_pkg::EST_W'(tofm_pkg::TC_RECIP);
				tc_nlo_q <= {tofm_pkg::NLO_W'(path_q) * tofm_pkg::NLO_W'(tofm_pkg::TC_K),
					{tofm_pkg::TC_K_SHIFT{1'b0}}};
			end
			tofm_pkg::TC_QD: begin
				tc_qd_q <= tofm_pkg::RES_W'(tc_est) * tofm_pkg::RES_W'(tofm_pkg::TC_DEN);
			end
			tofm_pkg::TC_FIX: begin
				tc_q <= (tc_res >= {1'b0, tofm_pkg::TC_DEN}) ? tc_est + 1'b1 : tc_est;
			end
			default: ;
		endcase
	end

	// reference time in 1/256 ps
	assign tc_sel = (light_q != '0) ? {light_q, {tofm_pkg::Q_FRAC{1'b0}}} : tc_q;

	// pipeline advances while the skid register is free
	assign adv      = !skid_vld_q;
	assign s_tready = adv && (tc_st_q == tofm_pkg::TC_DONE);
	assign in_vld   = s_tvalid && s_tready;

	assign in_req.tof = s_tdata[tofm_pkg::TOF_W-1:0];
	assign in_req.mom = s_tdata[tofm_pkg::TOF_W +: tofm_pkg::MOM_W];
	assign in_req.tc  = tc_sel;

	tofm_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_vld),
		.in_req  (in_req),
		.out_vld (p_vld),
		.out_res (p_res)
	);

	// output register and skid valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q || p_vld;
			skid_vld_q <= 1'b0;
		end else if (adv && p_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	// output register and skid payload
	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_res_q <= skid_vld_q ? skid_res_q : p_res;
		end else if (adv && p_vld) begin
			skid_res_q <= p_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_res_q.mass;
	assign m_tuser  = out_res_q.sat;

	// skid only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register holds a result while the output register is empty");

	// a path length write holds off requests until tc is rebuilt
	a_path_write_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_idx == tofm_pkg::CFG_PATH) |=> !s_tready)
		else $error("request accepted while the reference time is being rebuilt");

	// sequencer state stays one-hot
	a_tc_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(tc_st_q))
		else $error("reference time sequencer state is not one-hot");

	// a flagged nonzero mass is always the positive clip value
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] && m_tdata != '0) |-> (m_tdata == tofm_pkg::MASS_MAX))
		else $error("saturated result carries a value other than the clip limit");

endmodule

`default_nettype wire

FILE: rtl/core/tofm_pipe.sv
// arithmetic pipeline: squares, difference, square root, product and divide by reference time
`default_nettype none

module tofm_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_vld,
	input  tofm_pkg::req_t in_req,
	output logic           out_vld,
	output tofm_pkg::res_t out_res
);

	localparam int ROOT_LAST = tofm_pkg::ROOT_W - 1;
	localparam int QUO_LAST  = tofm_pkg::QUO_W - 1;

	// stage registers
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [tofm_pkg::TOF_W-1:0]    tof_s1;
	tofm_pkg::side_t               side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [tofm_pkg::TOFSQ_W-1:0]  tofsq_s2;
	logic [tofm_pkg::SQ_W-1:0]     tcsq_s2;
	logic [tofm_pkg::SQ_W-1:0]     rad_s3;
	logic [tofm_pkg::PROD_W-1:0]   prod_s4;
	logic                          ovf_s5;
	logic [tofm_pkg::TC_W-1:0]     rem_s5;
	logic [tofm_pkg::QUO_W-1:0]    low_s5;

	// square root stages, one root bit each
	logic                          sq_vld_s  [tofm_pkg::ROOT_W];
	logic [tofm_pkg::REM_W-1:0]    sq_rem_s  [tofm_pkg::ROOT_W];
	logic [tofm_pkg::ROOT_W-1:0]   sq_root_s [tofm_pkg::ROOT_W];
	logic [tofm_pkg::SQ_W-1:0]     sq_rad_s  [tofm_pkg::ROOT_W];
	tofm_pkg::side_t               sq_side_s [tofm_pkg::ROOT_W];

	// divide stages, one quotient bit each
	logic                          dv_vld_s  [tofm_pkg::QUO_W];
	logic [tofm_pkg::TC_W-1:0]     dv_rem_s  [tofm_pkg::QUO_W];
	logic [tofm_pkg::QUO_W-1:0]    dv_quo_s  [tofm_pkg::QUO_W];
	logic [tofm_pkg::QUO_W-1:0]    dv_low_s  [tofm_pkg::QUO_W];
	logic                          dv_ovf_s  [tofm_pkg::QUO_W];
	tofm_pkg::side_t               dv_side_s [tofm_pkg::QUO_W];

	logic [tofm_pkg::SQ_W-1:0]     a2;
	logic                          s3_neg;
	logic [tofm_pkg::HI_W-1:0]     prod_hi;
	logic [tofm_pkg::MASS_W-1:0]   mag;

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_vld_s[ROOT_LAST];
			v_s5 <= v_s4;
		end
	end

	// time difference of squares, sign picks the branch
	assign a2     = {tofsq_s2, {(2 * tofm_pkg::Q_FRAC){1'b0}}};
	assign s3_neg = a2 < tcsq_s2;

	// overflow test: quotient reaches 2^31 when the high product bits reach tc
	assign prod_hi = prod_s4[tofm_pkg::PROD_W-1 -: tofm_pkg::HI_W];

	// payload of the fixed stages
	always_ff @(posedge clk) begin
		if (adv) begin
			tof_s1       <= in_req.tof;
			side_s1.mom  <= in_req.mom;
			side_s1.tc   <= in_req.tc;
			side_s1.neg  <= 1'b0;
			side_s1.zero <= in_req.tc == '0;

			tofsq_s2 <= tofm_pkg::TOFSQ_W'(tof_s1) * tofm_pkg::TOFSQ_W'(tof_s1);
			tcsq_s2  <= tofm_pkg::SQ_W'(side_s1.tc) * tofm_pkg::SQ_W'(side_s1.tc);
			side_s2  <= side_s1;

			rad_s3  <= s3_neg ? (tcsq_s2 - a2) : (a2 - tcsq_s2);
			side_s3 <= '{mom: side_s2.mom, tc: side_s2.tc, neg: s3_neg, zero: side_s2.zero};

			prod_s4 <= tofm_pkg::PROD_W'(sq_side_s[ROOT_LAST].mom)
				* tofm_pkg::PROD_W'(sq_root_s[ROOT_LAST]);
			side_s4 <= sq_side_s[ROOT_LAST];

			ovf_s5  <= tofm_pkg::TC_W'(prod_hi) >= side_s4.tc;
			rem_s5  <= tofm_pkg::TC_W'(prod_hi);
			low_s5  <= prod_s4[tofm_pkg::QUO_W-1:0];
			side_s5 <= side_s4;
		end
	end

	// digit-by-digit square root, two radicand bits per stage
	for (genvar k = 0; k < tofm_pkg::ROOT_W; k++) begin : g_sqrt
		logic                        vld_in;
		logic [tofm_pkg::REM_W-1:0]  rem_in;
		logic [tofm_pkg::ROOT_W-1:0] root_in;
		logic [tofm_pkg::SQ_W-1:0]   rad_in;
		tofm_pkg::side_t             side_in;
		logic [tofm_pkg::REM_W+1:0]  cat;
		logic [tofm_pkg::REM_W+1:0]  trial;
		logic                        fit;

		if (k == 0) begin : g_head
			assign vld_in  = v_s3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_s3;
			assign side_in = side_s3;
		end else begin : g_tail
			assign vld_in  = sq_vld_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign rad_in  = sq_rad_s[k-1];
			assign side_in = sq_side_s[k-1];
		end

		assign cat   = {rem_in, rad_in[tofm_pkg::SQ_W-1-2*k -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign fit   = cat >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[k]  <= fit ? tofm_pkg::REM_W'(cat - trial) : cat[tofm_pkg::REM_W-1:0];
				sq_root_s[k] <= {root_in[tofm_pkg::ROOT_W-2:0], fit};
				sq_rad_s[k]  <= rad_in;
				sq_side_s[k] <= side_in;
			end
		end
	end

	// restoring divide of the product by tc, low quotient bits only
	for (genvar j = 0; j < tofm_pkg::QUO_W; j++) begin : g_div
		logic                       vld_in;
		logic [tofm_pkg::TC_W-1:0]  rem_in;
		logic [tofm_pkg::QUO_W-1:0] quo_in;
		logic [tofm_pkg::QUO_W-1:0] low_in;
		logic                       ovf_in;
		tofm_pkg::side_t            side_in;
		logic [tofm_pkg::TC_W:0]    cat;
		logic [tofm_pkg::TC_W:0]    dvs;
		logic                       fit;

		if (j == 0) begin : g_head
			assign vld_in  = v_s5;
			assign rem_in  = rem_s5;
			assign quo_in  = '0;
			assign low_in  = low_s5;
			assign ovf_in  = ovf_s5;
			assign side_in = side_s5;
		end else begin : g_tail
			assign vld_in  = dv_vld_s[j-1];
			assign rem_in  = dv_rem_s[j-1];
			assign quo_in  = dv_quo_s[j-1];
			assign low_in  = dv_low_s[j-1];
			assign ovf_in  = dv_ovf_s[j-1];
			assign side_in = dv_side_s[j-1];
		end

		assign cat = {rem_in, low_in[tofm_pkg::QUO_W-1-j]};
		assign dvs = {1'b0, side_in.tc};
		assign fit = cat >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j]  <= fit ? tofm_pkg::TC_W'(cat - dvs) : cat[tofm_pkg::TC_W-1:0];
				dv_quo_s[j]  <= {quo_in[tofm_pkg::QUO_W-2:0], fit};
				dv_low_s[j]  <= low_in;
				dv_ovf_s[j]  <= ovf_in;
				dv_side_s[j] <= side_in;
			end
		end
	end

	// sign, clipping and zero reference time
	assign mag = {1'b0, dv_quo_s[QUO_LAST]};

	always_comb begin
		out_vld = dv_vld_s[QUO_LAST];
		if (dv_side_s[QUO_LAST].zero) begin
			out_res.mass = '0;
			out_res.sat  = 1'b1;
		end else if (dv_ovf_s[QUO_LAST] && !dv_side_s[QUO_LAST].neg) begin
			out_res.mass = tofm_pkg::MASS_MAX;
			out_res.sat  = 1'b1;
		end else if (dv_side_s[QUO_LAST].neg) begin
			out_res.mass = -mag;
			out_res.sat  = 1'b0;
		end else begin
			out_res.mass = mag;
			out_res.sat  = 1'b0;
		end
	end

endmodule

`default_nettype wire
